// ===== src/rati_pkg.sv =====
// ============================================================================
// rati_pkg
// Shared types and constants of the radix text-to-integer unit: request and
// result payloads, configuration register indexes and character codes.
// ============================================================================
package rati_pkg;

    localparam int MAX_SYMBOLS_DEFAULT = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_LENGTH   = 2'd2;

    localparam int LENGTH_W = 5;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_string;
    } request_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               base_valid;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_FF) || (c == CHAR_TAB) ||
               (c == CHAR_LF) || (c == CHAR_CR) || (c == CHAR_VT);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CHAR_PLUS) || (c == CHAR_MINUS);
    endfunction

endpackage

// ===== src/radix_alphabet_text_to_integer_unit.sv =====
// ============================================================================
// radix_alphabet_text_to_integer_unit
// Converts a byte stream to a signed 32-bit integer in a radix whose digit
// symbols are set through the configuration channel.
// ============================================================================
// Usage:
//   Send one request per string byte on item/item_valid; the request with
//   end_of_string set closes the string and yields one result on
//   result/result_valid. Other requests yield nothing.
//   Configuration: write alphabet_low (index 0), alphabet_high (index 1) and
//   base_length (index 2) on cfg_valid/cfg_index/cfg_data while the unit is
//   idle; cfg_ready is always high.
//   Throughput: one request per cycle while item_stall is low. A request is
//   registered at the input, then the symbol compare and multiply-add act on
//   the input register, and a terminator's result goes to the result register.
//   When result_stall holds the result register full, a following terminator
//   waits in the input register and item_stall rises; other bytes keep
//   flowing.
//   Reset clears the parse state, the result valid flag and all configuration
//   registers (an empty alphabet, which is invalid).
// ============================================================================
module radix_alphabet_text_to_integer_unit #(
    parameter int MAX_SYMBOLS = rati_pkg::MAX_SYMBOLS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  rati_pkg::request_t                   item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output rati_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rati_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rati_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rati_pkg::*;

    localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    typedef enum logic [1:0] {PH_SKIP, PH_DIGITS, PH_DONE} phase_t;
    typedef enum logic [1:0] {SS_AWAIT, SS_SIGN, SS_DONE} sign_stage_t;
    typedef enum logic [1:0] {SF_PLUS, SF_MINUS, SF_ZERO} sign_factor_t;

    logic [7:0]          symbol_reg [MAX_SYMBOLS];
    logic [7:0]          symbol_next [MAX_SYMBOLS];
    logic [LENGTH_W-1:0] length_reg, length_next;

    logic                item_valid_reg, item_valid_next;
    request_t            item_reg, item_next;

    phase_t              phase_reg, phase_next;
    sign_stage_t         stage_reg, stage_next;
    sign_factor_t        factor_reg, factor_next;
    logic [31:0]         acc_reg, acc_next;

    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic                proc_go, proc_fire;
    logic [LENGTH_W-1:0] used_count;
    logic                digit_hit;
    logic [IDX_W-1:0]    digit;
    logic                alphabet_ok;
    logic [7:0]          c;

    assign cfg_ready    = 1'b1;
    assign c            = item_reg.character;
    assign proc_go      = !item_reg.end_of_string || !result_valid_reg || !result_stall;
    assign proc_fire    = item_valid_reg && proc_go;
    assign item_stall   = item_valid_reg && !proc_go;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign used_count = (length_reg <= LENGTH_W'(MAX_SYMBOLS)) ? length_reg : '0;

    always_comb
    begin
        digit_hit = 1'b0;
        digit     = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--)
        begin
            if ((LENGTH_W'(i) < used_count) && (symbol_reg[i] == c))
            begin
                digit_hit = 1'b1;
                digit     = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        alphabet_ok = (used_count >= LENGTH_W'(2));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (LENGTH_W'(i) < used_count)
            begin
                if ((symbol_reg[i] == CHAR_NUL) || is_space(symbol_reg[i]) ||
                    is_sign(symbol_reg[i]))
                begin
                    alphabet_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if ((LENGTH_W'(j) < used_count) && (symbol_reg[i] == symbol_reg[j]))
                    begin
                        alphabet_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            symbol_next[i] = symbol_reg[i];
            if (cfg_valid && cfg_ready)
            begin
                if ((i < 8) && (cfg_index == CFG_ALPHABET_LOW))
                begin
                    symbol_next[i] = cfg_data[(i % 8) * 8 +: 8];
                end
                if ((i >= 8) && (cfg_index == CFG_ALPHABET_HIGH))
                begin
                    symbol_next[i] = cfg_data[(i % 8) * 8 +: 8];
                end
            end
        end
        length_next = length_reg;
        if (cfg_valid && cfg_ready && (cfg_index == CFG_BASE_LENGTH))
        begin
            length_next = cfg_data[LENGTH_W-1:0];
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        if (item_valid && !item_stall)
        begin
            item_valid_next = 1'b1;
            item_next       = item;
        end
        else if (proc_fire)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        stage_next        = stage_reg;
        factor_next       = factor_reg;
        acc_next          = acc_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        if (proc_fire)
        begin
            if (item_reg.end_of_string)
            begin
                result_valid_next      = 1'b1;
                result_next.base_valid = alphabet_ok;
                result_next.value      = '0;
                if (alphabet_ok)
                begin
                    case (factor_reg)
                        SF_PLUS:  result_next.value = acc_reg;
                        SF_MINUS: result_next.value = 32'd0 - acc_reg;
                        default:  result_next.value = '0;
                    endcase
                end
                phase_next  = PH_SKIP;
                stage_next  = SS_AWAIT;
                factor_next = SF_PLUS;
                acc_next    = '0;
            end
            else
            begin
                case (stage_reg)
                    SS_AWAIT:
                    begin
                        if (!is_space(c))
                        begin
                            if (c == CHAR_MINUS)
                            begin
                                factor_next = SF_MINUS;
                                stage_next  = SS_SIGN;
                            end
                            else if (c == CHAR_PLUS)
                            begin
                                stage_next = SS_SIGN;
                            end
                            else
                            begin
                                stage_next = SS_DONE;
                            end
                        end
                    end
                    SS_SIGN:
                    begin
                        if (is_space(c))
                        begin
                            factor_next = SF_ZERO;
                        end
                        stage_next = SS_DONE;
                    end
                    default:
                    begin
                        stage_next = stage_reg;
                    end
                endcase

                if ((phase_reg == PH_DIGITS) ||
                    ((phase_reg == PH_SKIP) && !is_space(c) && !is_sign(c)))
                begin
                    if (digit_hit)
                    begin
                        phase_next = PH_DIGITS;
                        acc_next   = 32'(acc_reg * {27'd0, used_count}) + 32'(digit);
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SYMBOLS; i++)
            begin
                symbol_reg[i] <= '0;
            end
            length_reg       <= '0;
            item_valid_reg   <= 1'b0;
            phase_reg        <= PH_SKIP;
            stage_reg        <= SS_AWAIT;
            factor_reg       <= SF_PLUS;
            acc_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < MAX_SYMBOLS; i++)
            begin
                symbol_reg[i] <= symbol_next[i];
            end
            length_reg       <= length_next;
            item_valid_reg   <= item_valid_next;
            phase_reg        <= phase_next;
            stage_reg        <= stage_next;
            factor_reg       <= factor_next;
            acc_reg          <= acc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    a_result_from_terminator: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid_reg && item_reg.end_of_string))
        else $error("result without a terminator request");

    a_invalid_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.base_valid |-> result.value == 32'sd0)
        else $error("invalid alphabet with nonzero value");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && item_reg.end_of_string |=>
            acc_reg == '0 && phase_reg == PH_SKIP && factor_reg == SF_PLUS)
        else $error("parse state not cleared after terminator");

    a_stall_only_on_blocked_end: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> item_reg.end_of_string && result_valid_reg && result_stall)
        else $error("input stalled without a blocked result");

endmodule

// ===== verif/radix_alphabet_text_to_integer_unit_test.sv =====
// ============================================================================
// radix_alphabet_text_to_integer_unit_test
// Streams text bytes into the converter under a series of digit alphabets,
// predicts each terminator's integer value and alphabet check, and compares
// every result with the prediction while both sides idle and stall at random.
// ============================================================================
`timescale 1ns / 100ps

module radix_alphabet_text_to_integer_unit_test;

    import rati_pkg::*;

    localparam int SYMBOL_LIMIT = MAX_SYMBOLS_DEFAULT;
    localparam int IDLE_PCT     = 31;
    localparam int LONG_HOLD    = 300;

    localparam logic [7:0] BLANKS [6] = '{CHAR_SPACE, CHAR_FF, CHAR_TAB,
                                          CHAR_LF, CHAR_CR, CHAR_VT};
    localparam logic [7:0] BARRED [9] = '{CHAR_NUL, CHAR_SPACE, CHAR_FF, CHAR_TAB,
                                          CHAR_LF, CHAR_CR, CHAR_VT, CHAR_PLUS,
                                          CHAR_MINUS};

    typedef enum logic [1:0] {SCAN_LEADING, SCAN_DIGITS, SCAN_DONE} scan_phase_e;
    typedef enum logic [1:0] {SIGN_PENDING, SIGN_JUST_SEEN, SIGN_FIXED} sign_stage_e;
    typedef enum logic [1:0] {FACTOR_PLUS, FACTOR_MINUS, FACTOR_ZERO} sign_factor_e;

    typedef struct {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    request_t               item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    request_t     pending_bytes [$];
    result_t      expected_results [$];
    reg_write_t   pending_writes [$];

    logic [63:0]  alpha_lo;
    logic [63:0]  alpha_hi;
    logic [4:0]   radix_len;

    scan_phase_e  scan_phase;
    logic [31:0]  digit_sum;
    sign_stage_e  sign_stage;
    sign_factor_e sign_factor;

    logic [7:0]   gen_syms [16];
    int           gen_len;
    int           queued_bytes;
    int           mismatches;
    result_t      want_result;

    bit           quiet_run;
    bit           long_hold_arm;
    bit           long_hold_taken;
    int           hold_left;

    radix_alphabet_text_to_integer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic bit blank_char(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_FF || c == CHAR_TAB ||
               c == CHAR_LF || c == CHAR_CR || c == CHAR_VT;
    endfunction

    function automatic bit plain_symbol(input logic [7:0] c);
        return c != CHAR_NUL && !blank_char(c) && c != CHAR_PLUS && c != CHAR_MINUS;
    endfunction

    function automatic int symbols_in_use();
        return (radix_len <= SYMBOL_LIMIT) ? int'(radix_len) : 0;
    endfunction

    function automatic logic [7:0] symbol_at(input int i);
        return (i >= 8) ? alpha_hi[(i - 8) * 8 +: 8] : alpha_lo[i * 8 +: 8];
    endfunction

    function automatic bit alphabet_ok();
        int n;
        n = symbols_in_use();
        if (n < 2)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (!plain_symbol(symbol_at(i)))
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (symbol_at(j) == symbol_at(i))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int digit_index(input logic [7:0] c);
        for (int i = 0; i < symbols_in_use(); i++)
            if (symbol_at(i) == c)
                return i;
        return -1;
    endfunction

    task automatic clear_conversion();
        scan_phase  = SCAN_LEADING;
        digit_sum   = '0;
        sign_stage  = SIGN_PENDING;
        sign_factor = FACTOR_PLUS;
    endtask

    task automatic advance_conversion(input request_t req);
        result_t    r;
        logic [7:0] c;
        int         d;
        c = req.character;
        if (req.end_of_string)
        begin
            r.base_valid = alphabet_ok();
            r.value      = '0;
            if (r.base_valid && sign_factor == FACTOR_PLUS)
                r.value = digit_sum;
            else if (r.base_valid && sign_factor == FACTOR_MINUS)
                r.value = 32'd0 - digit_sum;
            expected_results.push_back(r);
            clear_conversion();
            return;
        end
        if (sign_stage == SIGN_PENDING)
        begin
            if (!blank_char(c))
            begin
                if (c == CHAR_MINUS)
                begin
                    sign_factor = FACTOR_MINUS;
                    sign_stage  = SIGN_JUST_SEEN;
                end
                else if (c == CHAR_PLUS)
                    sign_stage = SIGN_JUST_SEEN;
                else
                    sign_stage = SIGN_FIXED;
            end
        end
        else if (sign_stage == SIGN_JUST_SEEN)
        begin
            if (blank_char(c))
                sign_factor = FACTOR_ZERO;
            sign_stage = SIGN_FIXED;
        end
        if (scan_phase == SCAN_LEADING && !blank_char(c) && c != CHAR_PLUS &&
            c != CHAR_MINUS)
            scan_phase = SCAN_DIGITS;
        if (scan_phase == SCAN_DIGITS)
        begin
            d = digit_index(c);
            if (d >= 0)
                digit_sum = digit_sum * 32'(symbols_in_use()) + 32'(d);
            else
                scan_phase = SCAN_DONE;
        end
    endtask

    initial
        clear_conversion();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                advance_conversion(item);
                void'(pending_bytes.pop_front());
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_bytes.size() != 0 &&
                    (quiet_run || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    item_valid <= 1'b1;
                    item       <= pending_bytes[0];
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            alpha_lo  <= '0;
            alpha_hi  <= '0;
            radix_len <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ALPHABET_LOW:  alpha_lo  <= cfg_data;
                    CFG_ALPHABET_HIGH: alpha_hi  <= cfg_data;
                    CFG_BASE_LENGTH:   radix_len <= cfg_data[LENGTH_W-1:0];
                    default: ;
                endcase
                void'(pending_writes.pop_front());
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (pending_writes.size() != 0)
                begin
                    cfg_valid <= 1'b1;
                    cfg_index <= pending_writes[0].index;
                    cfg_data  <= pending_writes[0].data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                result_stall <= 1'b1;
                hold_left    <= hold_left - 1;
            end
            else if (long_hold_arm && !long_hold_taken)
            begin
                result_stall    <= 1'b1;
                hold_left       <= LONG_HOLD;
                long_hold_taken <= 1'b1;
            end
            else
                result_stall <= !quiet_run && $urandom_range(0, 99) < IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: value %0d base_valid %0b",
                       result.value, result.base_valid);
                mismatches++;
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (result.value !== want_result.value)
                begin
                    $error("value: expected %0d, got %0d", want_result.value, result.value);
                    mismatches++;
                end
                if (result.base_valid !== want_result.base_valid)
                begin
                    $error("base_valid: expected %0b, got %0b",
                           want_result.base_valid, result.base_valid);
                    mismatches++;
                end
            end
        end
    end

    task automatic push_char(input logic [7:0] c, input bit closing);
        request_t req;
        req.character     = c;
        req.end_of_string = closing;
        pending_bytes.push_back(req);
        queued_bytes++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], 1'b0);
    endtask

    task automatic close_string();
        push_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (4) @(posedge clk);
    endtask

    task automatic set_alphabet(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [4:0] len);
        reg_write_t w;
        w.index = CFG_ALPHABET_LOW;
        w.data  = lo;
        pending_writes.push_back(w);
        w.index = CFG_ALPHABET_HIGH;
        w.data  = hi;
        pending_writes.push_back(w);
        w.index = CFG_BASE_LENGTH;
        w.data  = 64'(len);
        pending_writes.push_back(w);
        gen_len = (len <= SYMBOL_LIMIT) ? int'(len) : 0;
        for (int i = 0; i < 8; i++)
        begin
            gen_syms[i]     = lo[i * 8 +: 8];
            gen_syms[i + 8] = hi[i * 8 +: 8];
        end
        while (pending_writes.size() != 0 || cfg_valid)
            @(posedge clk);
    endtask

    task automatic random_alphabet(input int forced_len);
        logic [7:0]  s [16];
        logic [63:0] lo;
        logic [63:0] hi;
        int          n;
        int          flaw;
        bit          clash;
        n = (forced_len != 0) ? forced_len : $urandom_range(2, SYMBOL_LIMIT);
        for (int i = 0; i < 16; i++)
        begin
            do
            begin
                s[i]  = 8'($urandom_range(0, 255));
                clash = 1'b0;
                for (int j = 0; j < i; j++)
                    if (s[j] == s[i])
                        clash = 1'b1;
            end
            while (i < n && (clash || !plain_symbol(s[i])));
        end
        flaw = (forced_len != 0) ? 11 : $urandom_range(0, 11);
        case (flaw)
            0: s[$urandom_range(0, n - 1)] = BARRED[$urandom_range(0, 8)];
            1: s[$urandom_range(1, n - 1)] = s[0];
            2: n = $urandom_range(0, 1);
            3: n = $urandom_range(SYMBOL_LIMIT + 1, 31);
            default: ;
        endcase
        for (int i = 0; i < 8; i++)
        begin
            lo[i * 8 +: 8] = s[i];
            hi[i * 8 +: 8] = s[i + 8];
        end
        set_alphabet(lo, hi, n[4:0]);
    endtask

    task automatic queue_string();
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(0, 12))
                push_char(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(0, 3))
                push_char(BLANKS[$urandom_range(0, 5)], 1'b0);
            repeat ($urandom_range(0, 2))
                push_char($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS, 1'b0);
            if ($urandom_range(0, 9) == 0)
                push_char(BLANKS[$urandom_range(0, 5)], 1'b0);
            repeat ($urandom_range(0, 12))
                push_char(gen_len > 0 ? gen_syms[$urandom_range(0, gen_len - 1)]
                                      : 8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 4))
                    push_char(8'($urandom_range(0, 255)), 1'b0);
        end
        close_string();
    endtask

    task automatic run_strings(input int count);
        int start;
        start = queued_bytes;
        while (queued_bytes - start < count)
            queue_string();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_text("-");
        close_string();
        close_string();
        push_text("1");
        close_string();
        settle();

        set_alphabet(64'h3736353433323130, 64'h0000000000003938, 5'd10);
        push_char(CHAR_TAB, 1'b0);
        push_text("-12a3");
        close_string();
        push_text("+ 5");
        close_string();
        push_char(CHAR_LF, 1'b0);
        push_char(CHAR_VT, 1'b0);
        push_char(CHAR_FF, 1'b0);
        push_char(CHAR_CR, 1'b0);
        push_char(CHAR_SPACE, 1'b0);
        push_text("9");
        close_string();
        push_char(CHAR_NUL, 1'b0);
        push_text("7");
        close_string();
        push_char(8'hFF, 1'b0);
        close_string();
        settle();

        set_alphabet('1, '1, 5'd31);
        push_char(8'hFF, 1'b0);
        close_string();
        settle();

        for (int phase = 0; phase < 14; phase++)
        begin
            random_alphabet(phase == 0 ? SYMBOL_LIMIT : (phase == 1 ? 2 : 0));
            quiet_run = (phase == 3);
            if (phase == 5)
                long_hold_arm = 1'b1;
            if (phase == 7)
            begin
                run_strings(65);
                drain();
                run_strings(65);
            end
            else
                run_strings(135);
            settle();
            quiet_run = 1'b0;
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
